@@ rtl/qpv_pkg.sv @@
// ----------------------------------------------------------------------------
// qpv_pkg
// Shared constants and types of the q-gram parity vector builder.
// ----------------------------------------------------------------------------
package qpv_pkg;

  // q-gram length in bases and vector size in bytes
  localparam int QGRAM_LEN    = 5;
  localparam int VECTOR_BYTES = 128;

  // derived sizes
  localparam int CODE_W      = 2;
  localparam int QGRAM_W     = 2 * QGRAM_LEN;
  localparam int WORD_W      = 64;
  localparam int BIT_SEL_W   = 6;
  localparam int NUM_WORDS   = VECTOR_BYTES / 8;
  localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
  localparam int VEC_BIT_W   = $clog2(8 * VECTOR_BYTES);
  localparam int EMIT_CNT_W  = $clog2(NUM_WORDS + 1);
  localparam int PFX_W       = 3;
  localparam int OUT_IDX_W   = 4;

  // toggle request for one base
  typedef struct packed {
    logic                  toggle;
    logic [WORD_IDX_W-1:0] word_sel;
    logic [BIT_SEL_W-1:0]  bit_sel;
  } qpv_toggle_t;

  // memory access request
  typedef struct packed {
    logic                  clear;
    logic                  rd_en;
    logic [WORD_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [WORD_IDX_W-1:0] wr_addr;
    logic [WORD_W-1:0]     wr_data;
  } qpv_mem_req_t;

endpackage

@@ rtl/qpv_in_if.sv @@
// ----------------------------------------------------------------------------
// qpv_in_if
// Base stream channel: one base code with sequence marks per request.
// ----------------------------------------------------------------------------
interface qpv_in_if
  import qpv_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] base_code;
  logic              carries_base;
  logic              seq_start;
  logic              seq_end;

  modport source (output valid, base_code, carries_base, seq_start, seq_end, input ready);
  modport sink   (input valid, base_code, carries_base, seq_start, seq_end, output ready);
endinterface

@@ rtl/qpv_out_if.sv @@
// ----------------------------------------------------------------------------
// qpv_out_if
// Vector word channel: one 64-bit parity word per request.
// ----------------------------------------------------------------------------
interface qpv_out_if
  import qpv_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [OUT_IDX_W-1:0] word_index;
  logic [WORD_W-1:0]    vector_word;
  logic                 last_word;

  modport source (output valid, word_index, vector_word, last_word, input ready);
  modport sink   (input valid, word_index, vector_word, last_word, output ready);
endinterface

@@ rtl/qpv_kmer_track.sv @@
// ----------------------------------------------------------------------------
// qpv_kmer_track
// Rolling q-gram register and prefix counter; yields the toggle per base.
// ----------------------------------------------------------------------------
module qpv_kmer_track
  import qpv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [CODE_W-1:0] base_code,
  input  logic              carries_base,
  input  logic              seq_start,
  output qpv_toggle_t       tgl
);

  logic [QGRAM_W-1:0]   recent_r, recent_nxt, recent_base;
  logic [PFX_W-1:0]     prefix_r, prefix_nxt, prefix_base;
  logic [VEC_BIT_W-1:0] gram;
  logic                 full;

  // start mark clears the history before the base is shifted in
  always_comb begin
    recent_base = seq_start ? '0 : recent_r;
    prefix_base = seq_start ? '0 : prefix_r;
    full        = (prefix_base >= PFX_W'(QGRAM_LEN - 1));
    recent_nxt  = recent_base;
    prefix_nxt  = prefix_base;
    if (carries_base) begin
      recent_nxt = QGRAM_W'({recent_base, base_code});
      if (!full) begin
        prefix_nxt = prefix_base + PFX_W'(1);
      end
    end
  end

  // q-gram selects word and bit of the vector
  assign gram         = VEC_BIT_W'(recent_nxt);
  assign tgl.toggle   = carries_base && full;
  assign tgl.word_sel = gram[VEC_BIT_W-1:BIT_SEL_W];
  assign tgl.bit_sel  = gram[BIT_SEL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= '0;
      prefix_r <= '0;
    end else if (take) begin
      recent_r <= recent_nxt;
      prefix_r <= prefix_nxt;
    end
  end

endmodule

@@ rtl/qpv_parity_mem.sv @@
// ----------------------------------------------------------------------------
// qpv_parity_mem
// Parity word memory with registered read and per-word valid bits.
// ----------------------------------------------------------------------------
module qpv_parity_mem
  import qpv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  qpv_mem_req_t      req,
  output logic [WORD_W-1:0] rd_word
);

  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] valid_r;
  logic [WORD_W-1:0]    rd_data_r;
  logic                 rd_valid_r;

  // storage array, one write and one read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  // valid bits: a cleared word reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.clear) begin
        valid_r <= '0;
      end else if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.rd_addr] && !req.clear;
      end
    end
  end

  assign rd_word = rd_valid_r ? rd_data_r : '0;

endmodule

@@ rtl/qpv_fsm_top.sv @@
// ----------------------------------------------------------------------------
// qpv_fsm_top
// Sequencer: read-modify-write of parity words and vector emission.
// ----------------------------------------------------------------------------
module qpv_fsm_top
  import qpv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  qpv_in_if.sink            in_ch,
  qpv_out_if.source         out_ch,
  input  qpv_toggle_t       tgl,
  input  logic [WORD_W-1:0] rd_word,
  output logic              take,
  output qpv_mem_req_t      mem_req
);

  typedef enum logic [1:0] {S_IDLE, S_TOGGLE, S_EMIT} state_t;

  state_t                state_r;
  logic                  end_r;
  logic [WORD_IDX_W-1:0] wsel_r;
  logic [BIT_SEL_W-1:0]  bsel_r;
  logic [EMIT_CNT_W-1:0] issue_cnt_r;
  logic                  pend_r;
  logic [WORD_IDX_W-1:0] pend_idx_r;
  logic                  out_valid_r;
  logic [WORD_IDX_W-1:0] out_idx_r;
  logic [WORD_W-1:0]     out_word_r;
  logic                  out_last_r;
  logic                  consume;
  logic                  issue;
  logic                  issue_left;

  assign in_ch.ready = (state_r == S_IDLE);
  assign take        = in_ch.valid && in_ch.ready;

  // emission pipeline: memory read register feeds the output register
  assign issue_left = (issue_cnt_r < EMIT_CNT_W'(NUM_WORDS));
  assign consume    = (state_r == S_EMIT) && pend_r && (!out_valid_r || out_ch.ready);
  assign issue      = (state_r == S_EMIT) && issue_left && (!pend_r || consume);

  // memory requests per state
  always_comb begin
    mem_req         = '0;
    mem_req.wr_addr = wsel_r;
    mem_req.wr_data = rd_word ^ (WORD_W'(1) << bsel_r);
    unique case (state_r)
      S_IDLE: begin
        mem_req.clear   = take && in_ch.seq_start;
        mem_req.rd_en   = take && tgl.toggle;
        mem_req.rd_addr = tgl.word_sel;
      end
      S_TOGGLE: begin
        mem_req.wr_en = 1'b1;
      end
      S_EMIT: begin
        mem_req.rd_en   = issue;
        mem_req.rd_addr = issue_cnt_r[WORD_IDX_W-1:0];
      end
      default: begin
        mem_req.rd_en = 1'b0;
      end
    endcase
  end

  // state, emission counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      end_r       <= 1'b0;
      issue_cnt_r <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            end_r       <= in_ch.seq_end;
            wsel_r      <= tgl.word_sel;
            bsel_r      <= tgl.bit_sel;
            issue_cnt_r <= '0;
            pend_r      <= 1'b0;
            if (tgl.toggle) begin
              state_r <= S_TOGGLE;
            end else if (in_ch.seq_end) begin
              state_r <= S_EMIT;
            end
          end
        end
        S_TOGGLE: begin
          state_r <= end_r ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (issue) begin
            issue_cnt_r <= issue_cnt_r + EMIT_CNT_W'(1);
            pend_idx_r  <= issue_cnt_r[WORD_IDX_W-1:0];
            pend_r      <= 1'b1;
          end else if (consume) begin
            pend_r <= 1'b0;
          end
          if (consume && !issue_left) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (consume) begin
        out_valid_r <= 1'b1;
        out_idx_r   <= pend_idx_r;
        out_word_r  <= rd_word;
        out_last_r  <= (pend_idx_r == WORD_IDX_W'(NUM_WORDS - 1));
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.word_index  = OUT_IDX_W'(out_idx_r);
  assign out_ch.vector_word = out_word_r;
  assign out_ch.last_word   = out_last_r;

  // emission never issues more words than the vector holds
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    issue_cnt_r <= EMIT_CNT_W'(NUM_WORDS))
    else $error("emission count overran the vector");

  // an end mark always leads into emission
  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_ch.seq_end) |=> (state_r != S_IDLE))
    else $error("end mark did not start emission");

  // the write-back state is always left again in the next cycle
  a_toggle_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TOGGLE) |=> (state_r != S_TOGGLE))
    else $error("read-modify-write stuck");

  // last mark only on the final word
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_idx_r == WORD_IDX_W'(NUM_WORDS - 1)))
    else $error("last mark on wrong word");

endmodule

@@ rtl/qgram_parity_vector.sv @@
// ----------------------------------------------------------------------------
// qgram_parity_vector
// Builds a q-gram parity vector per nucleotide sequence and emits it as words.
// ----------------------------------------------------------------------------
// One request is taken per cycle while the block is idle. A request whose base
// completes a q-gram also passes through a write-back state, because the parity
// word goes through a read-modify-write in the word memory, whose read is
// registered. A request with the end mark then emits all 16 words, one per cycle
// while the sink takes them, and output stalls hold the emission. A start mark
// clears the vector at once through per-word valid bits, with no clearing pass.
module qgram_parity_vector
  import qpv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  qpv_in_if.sink    in_ch,
  qpv_out_if.source out_ch
);

  qpv_toggle_t       tgl;
  qpv_mem_req_t      mem_req;
  logic [WORD_W-1:0] rd_word;
  logic              take;

  // q-gram history
  qpv_kmer_track u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .base_code    (in_ch.base_code),
    .carries_base (in_ch.carries_base),
    .seq_start    (in_ch.seq_start),
    .tgl          (tgl)
  );

  // parity word store
  qpv_parity_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_word (rd_word)
  );

  // sequencer and output register
  qpv_fsm_top u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .tgl     (tgl),
    .rd_word (rd_word),
    .take    (take),
    .mem_req (mem_req)
  );

endmodule

@@ verif/qpv_vector_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qpv_vector_check
// Watches the base stream and the vector word stream of the parity vector
// builder, keeps its own copy of the q-gram window and parity vector, and
// compares every emitted word with the predicted one.
// ----------------------------------------------------------------------------
module qpv_vector_check
  import qpv_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  qpv_in_if    in_ch,
  qpv_out_if   out_ch,
  output int   fail_count,
  output int   words_due
);

  typedef struct packed {
    logic [OUT_IDX_W-1:0] idx;
    logic [WORD_W-1:0]    bits;
    logic                 last;
  } vec_word_t;

  // predicted state of the block
  logic [QGRAM_W-1:0] window;
  logic [PFX_W-1:0]   bases_seen;
  logic [WORD_W-1:0]  parity [NUM_WORDS];
  vec_word_t          pending_words [$];

  // apply one accepted request to the predicted vector
  task automatic absorb_request(input logic [CODE_W-1:0] code, input logic has_base,
                                input logic start, input logic fin);
    logic [VEC_BIT_W-1:0]  g;
    logic [WORD_IDX_W-1:0] wi;
    logic [BIT_SEL_W-1:0]  bi;
    vec_word_t             w;
    if (start) begin
      window     = '0;
      bases_seen = '0;
      foreach (parity[i]) parity[i] = '0;
    end
    if (has_base) begin
      window = QGRAM_W'({window, code});
      if (bases_seen >= PFX_W'(QGRAM_LEN - 1)) begin
        g  = VEC_BIT_W'(window);
        wi = WORD_IDX_W'(g >> BIT_SEL_W);
        bi = g[BIT_SEL_W-1:0];
        parity[wi][bi] = ~parity[wi][bi];
      end else begin
        bases_seen = bases_seen + 1'b1;
      end
    end
    // whole vector goes out on the end mark, unchanged
    if (fin) begin
      for (int k = 0; k < NUM_WORDS; k++) begin
        w.idx  = OUT_IDX_W'(k);
        w.bits = parity[k];
        w.last = (k == NUM_WORDS - 1);
        pending_words = {pending_words, w};
      end
    end
  endtask

  // compare emitted words, then take in new requests
  always @(posedge clk) begin
    vec_word_t want;
    if (!rst_n) begin
      window     = '0;
      bases_seen = '0;
      foreach (parity[i]) parity[i] = '0;
      pending_words.delete();
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_words.size() == 0) begin
          $error("unexpected vector word: word_index=%0d vector_word=%h",
                 out_ch.word_index, out_ch.vector_word);
          fail_count++;
        end else begin
          want = pending_words.pop_front();
          if (out_ch.word_index !== want.idx) begin
            $error("word_index: expected %0d, got %0d", want.idx, out_ch.word_index);
            fail_count++;
          end
          if (out_ch.vector_word !== want.bits) begin
            $error("vector_word: expected %h, got %h", want.bits, out_ch.vector_word);
            fail_count++;
          end
          if (out_ch.last_word !== want.last) begin
            $error("last_word: expected %0b, got %0b", want.last, out_ch.last_word);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        absorb_request(in_ch.base_code, in_ch.carries_base, in_ch.seq_start, in_ch.seq_end);
    end
    words_due = pending_words.size();
  end

endmodule

@@ verif/tb_qgram_parity_vector.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_qgram_parity_vector
// Drives base requests into the parity vector builder: a directed set of
// corner sequences, then random well-formed and broken sequences with random
// gaps on the sender and random stalls on the word sink. Checking is done by
// qpv_vector_check.
// ----------------------------------------------------------------------------
module tb_qgram_parity_vector;
  import qpv_pkg::*;

  localparam int CYCLE_LIMIT  = 250000;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_ITEMS = 320;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   words_due;
  int   cycle_count = 0;
  int   items_sent  = 0;
  bit   calm        = 1'b0;

  qpv_in_if  in_ch ();
  qpv_out_if out_ch ();

  qgram_parity_vector dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  qpv_vector_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // idle cycles before the next request on either side
  function automatic int draw_wait();
    if (calm)
      return 0;
    return $urandom_range(0, 8);
  endfunction

  // one base request, held until the block takes it
  task automatic send_base(input logic [CODE_W-1:0] code, input bit has_base,
                           input bit start, input bit fin);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.base_code    = code;
    in_ch.carries_base = has_base;
    in_ch.seq_start    = start;
    in_ch.seq_end      = fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // hold off the sender until every emitted word has been taken
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (words_due != 0) @(negedge clk);
  endtask

  // run of random bases, optionally framed by start and end marks
  task automatic send_sequence(input int n, input bit with_start, input bit with_end);
    for (int i = 0; i < n; i++)
      send_base(CODE_W'($urandom_range(0, 3)), $urandom_range(0, 9) != 0,
                with_start && (i == 0), with_end && (i == n - 1));
  endtask

  // word sink with random stalls
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    int kind;
    int seq_no;
    int target;
    in_ch.valid        = 1'b0;
    in_ch.base_code    = '0;
    in_ch.carries_base = 1'b0;
    in_ch.seq_start    = 1'b0;
    in_ch.seq_end      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty sequence, then an end mark alone with a code that must be ignored
    send_base(2'd0, 1'b0, 1'b1, 1'b1);
    send_base(2'd3, 1'b0, 1'b0, 1'b1);
    // sequence shorter than a q-gram, with one request carrying no base
    send_base(2'd1, 1'b1, 1'b1, 1'b0);
    send_base(2'd2, 1'b1, 1'b0, 1'b0);
    send_base(2'd3, 1'b0, 1'b0, 1'b0);
    send_base(2'd0, 1'b1, 1'b0, 1'b0);
    send_base(2'd3, 1'b1, 1'b0, 1'b1);
    // all-A q-gram: lowest bit of the vector
    send_base(2'd0, 1'b1, 1'b1, 1'b0);
    repeat (3) send_base(2'd0, 1'b1, 1'b0, 1'b0);
    send_base(2'd0, 1'b1, 1'b0, 1'b1);
    // all-T q-gram: highest bit of the vector
    send_base(2'd3, 1'b1, 1'b1, 1'b0);
    repeat (3) send_base(2'd3, 1'b1, 1'b0, 1'b0);
    send_base(2'd3, 1'b1, 1'b0, 1'b1);
    // repeated end mark, base outside a sequence toggles the same bit back
    send_base(2'd0, 1'b0, 1'b0, 1'b1);
    send_base(2'd3, 1'b1, 1'b0, 1'b0);
    send_base(2'd0, 1'b0, 1'b0, 1'b1);
    // start, base and end on one request
    send_base(2'd2, 1'b1, 1'b1, 1'b1);
    wait_drained();

    // random sequences, mostly well formed
    target = items_sent + RANDOM_ITEMS;
    seq_no = 0;
    while (items_sent < target) begin
      calm = ($urandom_range(0, 5) == 0);
      if (seq_no == 4 || seq_no == 12)
        wait_drained();
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          // loose requests with random marks
          repeat ($urandom_range(1, 3))
            send_base(CODE_W'($urandom_range(0, 3)), $urandom_range(0, 1) != 0,
                      $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
        end
        1: begin
          // sequence that never ends
          send_sequence($urandom_range(1, 20), 1'b1, 1'b0);
        end
        2: begin
          // sequence without a start mark keeps the old vector
          send_sequence($urandom_range(1, 20), 1'b0, 1'b1);
        end
        default: begin
          if ($urandom_range(0, 7) == 0)
            send_sequence($urandom_range(1, 4), 1'b1, 1'b1);
          else
            send_sequence($urandom_range(5, 40), 1'b1, 1'b1);
        end
      endcase
      seq_no++;
    end
    calm = 1'b0;

    // let the last words drain
    in_ch.valid = 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && words_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/qpv_pkg.sv
rtl/qpv_in_if.sv
rtl/qpv_out_if.sv
rtl/qpv_kmer_track.sv
rtl/qpv_parity_mem.sv
rtl/qpv_fsm_top.sv
rtl/qgram_parity_vector.sv
verif/qpv_vector_check.sv
verif/tb_qgram_parity_vector.sv
